>>> rtl/core/gr2pm_pkg.sv
// ----------------------------------------------------------------------------
// gr2pm_pkg
// Shared types and constants of the gyro rate to pointer motion block.
// ----------------------------------------------------------------------------
package gr2pm_pkg;

	localparam int SENS_W = 5;
	localparam int DB_W   = 8;
	localparam int MAG_W  = 17;
	localparam int PROD_W = 36;
	localparam int SIZE_W = 6;
	localparam int MOVE_W = 7;

	localparam logic [SENS_W-1:0] SENS_RST = 5'd13;
	localparam logic [DB_W-1:0]   DB_RST   = 8'd20;

	localparam logic CFG_SENS = 1'b0;
	localparam logic CFG_DB   = 1'b1;

	localparam logic [17:0]       RECIP5_WIDE  = 18'd209716;
	localparam int                RECIP5_SHIFT = 20;
	localparam logic [15:0]       RECIP5_NARROW = 16'd205;
	localparam logic [MAG_W-1:0]  BIG_MAG      = 17'd80;
	localparam logic [SIZE_W-1:0] REV_SIZE     = 6'd3;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	typedef struct packed {
		logic valid;
		logic active;
	} ctl_t;

	typedef struct packed {
		logic              still;
		logic              pos;
		logic [SIZE_W-1:0] size;
	} lane_res_t;

endpackage

>>> rtl/core/gr2pm_front.sv
// ----------------------------------------------------------------------------
// gr2pm_front
// Input stage: forms the X magnitude and the scaled Y product per request.
// ----------------------------------------------------------------------------
module gr2pm_front import gr2pm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              in_valid,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_z,
	input  logic              active,
	output ctl_t              ctl_s1,
	output logic [MAG_W-1:0]  x_mag_s1,
	output logic              x_pos_s1,
	output logic [PROD_W-1:0] y_prod_s1,
	output logic              y_pos_s1
);

	logic signed [MAG_W-1:0] x_ext;
	logic signed [MAG_W-1:0] z_ext;
	logic [MAG_W-1:0]        x_abs;
	logic [MAG_W-1:0]        z_abs;
	logic [19:0]             z7_wide;
	logic [17:0]             z7;

	always_comb begin
		x_ext   = MAG_W'(gyro_x);
		z_ext   = MAG_W'(gyro_z);
		x_abs   = x_ext[MAG_W-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
		z_abs   = z_ext[MAG_W-1] ? MAG_W'(-z_ext) : MAG_W'(z_ext);
		z7_wide = {z_abs, 3'b000} - 20'(z_abs);
		z7      = z7_wide[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.active <= active;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_mag_s1  <= x_abs;
			x_pos_s1  <= gyro_x[15];
			y_prod_s1 <= PROD_W'(z7) * PROD_W'(RECIP5_WIDE);
			y_pos_s1  <= !gyro_z[15] && (gyro_z != 16'sd0);
		end
	end

endmodule

>>> rtl/core/gr2pm_lane.sv
// ----------------------------------------------------------------------------
// gr2pm_lane
// One axis: deadband test and clamped step size from the reading magnitude.
// ----------------------------------------------------------------------------
module gr2pm_lane import gr2pm_pkg::*; (
	input  logic              clk,
	input  logic              advance,
	input  logic [SENS_W-1:0] sensitivity,
	input  logic [DB_W-1:0]   deadband,
	input  logic [MAG_W-1:0]  mag,
	input  logic              pos,
	output lane_res_t         res_s3
);

	logic              still_s2;
	logic              pos_s2;
	logic              big_s2;
	logic [11:0]       prod_s2;
	logic [SIZE_W-1:0] sens_p3;
	logic [SIZE_W-1:0] hi;
	logic [7:0]        quot_in;
	logic [15:0]       quot_wide;
	logic [SIZE_W-1:0] quot;
	logic [SIZE_W-1:0] size_c;

	always_comb begin
		sens_p3   = SIZE_W'(sensitivity) + SIZE_W'(3);
		hi        = SIZE_W'(sensitivity) + SIZE_W'(2);
		quot_in   = prod_s2[11:4];
		quot_wide = 16'(quot_in) * RECIP5_NARROW;
		quot      = quot_wide[15:10];
		if (big_s2)
			size_c = hi;
		else if (quot == '0)
			size_c = SIZE_W'(1);
		else
			size_c = quot;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			still_s2     <= mag < MAG_W'(deadband);
			pos_s2       <= pos;
			big_s2       <= mag >= BIG_MAG;
			prod_s2      <= 12'(13'(mag[6:0]) * 13'(sens_p3));
			res_s3.still <= still_s2;
			res_s3.pos   <= pos_s2;
			res_s3.size  <= size_c;
		end
	end

endmodule

>>> rtl/core/gr2pm_merge.sv
// ----------------------------------------------------------------------------
// gr2pm_merge
// Combines both lanes against the held directions and registers the result.
// ----------------------------------------------------------------------------
module gr2pm_merge import gr2pm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl_s3,
	input  lane_res_t                res_x,
	input  lane_res_t                res_y,
	input  logic                     out_ready,
	output logic                     advance,
	output logic                     out_valid,
	output logic signed [MOVE_W-1:0] move_x,
	output logic signed [MOVE_W-1:0] move_y,
	output logic                     reversal
);

	dir_t                     held_x_q, held_y_q;
	dir_t                     hx, hy, dx, dy;
	logic                     out_valid_q;
	logic signed [MOVE_W-1:0] move_x_q, move_y_q;
	logic                     rev_q;
	logic signed [MOVE_W-1:0] mx, my;
	logic [SIZE_W-1:0]        sy;
	logic                     rev_c;

	function automatic logic signed [MOVE_W-1:0] step(dir_t d, logic [SIZE_W-1:0] s);
		logic signed [MOVE_W-1:0] m;
		m = MOVE_W'(s);
		case (d)
			DIR_POS: step = m;
			DIR_NEG: step = -m;
			default: step = '0;
		endcase
	endfunction

	always_comb begin
		dx    = res_x.still ? DIR_NONE : (res_x.pos ? DIR_POS : DIR_NEG);
		dy    = res_y.still ? DIR_NONE : (res_y.pos ? DIR_POS : DIR_NEG);
		hx    = held_x_q;
		hy    = held_y_q;
		mx    = '0;
		my    = '0;
		sy    = res_y.size;
		rev_c = 1'b0;

		if (dx == DIR_NONE) begin
			mx = step(hx, res_x.size);
		end else if (dx == hx || hx == DIR_NONE) begin
			mx = step(dx, res_x.size);
			hx = dx;
		end else begin
			rev_c = 1'b1;
			hx    = DIR_NONE;
			hy    = DIR_NONE;
			sy    = REV_SIZE;
		end

		if (dy == DIR_NONE) begin
			my = step(hy, sy);
		end else if (dy == hy || hy == DIR_NONE) begin
			my = step(dy, sy);
			hy = dy;
		end else begin
			rev_c = 1'b1;
			hx    = DIR_NONE;
			hy    = DIR_NONE;
			mx    = '0;
			my    = '0;
		end
	end

	assign advance   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign move_x    = move_x_q;
	assign move_y    = move_y_q;
	assign reversal  = rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_x_q    <= DIR_NONE;
			held_y_q    <= DIR_NONE;
		end else if (advance) begin
			out_valid_q <= ctl_s3.valid && ctl_s3.active;
			if (ctl_s3.valid) begin
				held_x_q <= ctl_s3.active ? hx : DIR_NONE;
				held_y_q <= ctl_s3.active ? hy : DIR_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			move_x_q <= mx;
			move_y_q <= my;
			rev_q    <= rev_c;
		end
	end

	a_rev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rev_q |-> move_x_q == '0)
		else $error("reversal result carries a nonzero X move");

	a_rev_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl_s3.valid && ctl_s3.active && rev_c
		|=> held_x_q == DIR_NONE)
		else $error("held X direction not cleared on reversal");

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl_s3.valid && !ctl_s3.active
		|=> held_x_q == DIR_NONE && held_y_q == DIR_NONE)
		else $error("held directions not cleared");

	a_held_moves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rev_q && held_x_q != DIR_NONE |-> move_x_q != '0)
		else $error("held X direction without X move");

	a_held_moves_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rev_q && held_y_q != DIR_NONE |-> move_y_q != '0)
		else $error("held Y direction without Y move");

endmodule

>>> rtl/core/gyro_rate_to_pointer_motion.sv
// ----------------------------------------------------------------------------
// gyro_rate_to_pointer_motion
// Turns gyro rate samples into pointer steps with direction memory per axis.
//
// Channel   Dir  Bits  Contents
// s_axis    in   32    tdata: gyro_x[15:0], gyro_z[31:16]; tuser: active
// m_axis    out  16    tdata: move_x[6:0], move_y[13:7], zero fill; tuser: reversal
// cfg       in   8     cfg_index 0 sensitivity, 1 deadband
//
// One request per cycle unless a stalled result holds the pipeline; four register
// stages (input, two lane stages, merge) lie between an accepted request and its result.
// The direction memory is read and updated in the single merge stage.
// A stalled result holds the whole pipeline; s_tready follows the output slot.
// Reset: sensitivity 13, deadband 20, no remembered directions.
// ----------------------------------------------------------------------------
module gyro_rate_to_pointer_motion import gr2pm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // gyro_x, gyro_z
	input  logic        s_tuser,   // active
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // move_x, move_y, zero fill
	output logic        m_tuser    // reversal
);

	logic [SENS_W-1:0]        sensitivity_q;
	logic [DB_W-1:0]          deadband_q;
	logic                     advance;
	ctl_t                     ctl_s1, ctl_s2, ctl_s3;
	logic [MAG_W-1:0]         x_mag_s1;
	logic                     x_pos_s1;
	logic [PROD_W-1:0]        y_prod_s1;
	logic                     y_pos_s1;
	logic [MAG_W-1:0]         y_mag;
	lane_res_t                res_x, res_y;
	logic signed [MOVE_W-1:0] move_x, move_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensitivity_q <= SENS_RST;
			deadband_q    <= DB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SENS: sensitivity_q <= cfg_wdata[SENS_W-1:0];
				CFG_DB:   deadband_q    <= cfg_wdata[DB_W-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (advance) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign s_tready = advance;
	assign y_mag    = MAG_W'(y_prod_s1[PROD_W-1:RECIP5_SHIFT]);

	gr2pm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (s_tvalid),
		.gyro_x    (s_tdata[15:0]),
		.gyro_z    (s_tdata[31:16]),
		.active    (s_tuser),
		.ctl_s1    (ctl_s1),
		.x_mag_s1  (x_mag_s1),
		.x_pos_s1  (x_pos_s1),
		.y_prod_s1 (y_prod_s1),
		.y_pos_s1  (y_pos_s1)
	);

	gr2pm_lane u_lane_x (
		.clk         (clk),
		.advance     (advance),
		.sensitivity (sensitivity_q),
		.deadband    (deadband_q),
		.mag         (x_mag_s1),
		.pos         (x_pos_s1),
		.res_s3      (res_x)
	);

	gr2pm_lane u_lane_y (
		.clk         (clk),
		.advance     (advance),
		.sensitivity (sensitivity_q),
		.deadband    (deadband_q),
		.mag         (y_mag),
		.pos         (y_pos_s1),
		.res_s3      (res_y)
	);

	gr2pm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s3    (ctl_s3),
		.res_x     (res_x),
		.res_y     (res_y),
		.out_ready (m_tready),
		.advance   (advance),
		.out_valid (m_tvalid),
		.move_x    (move_x),
		.move_y    (move_y),
		.reversal  (m_tuser)
	);

	assign m_tdata = {2'b00, move_y, move_x};

endmodule
